FILE: src/tfs_pkg.sv
// Package for the clock time setter: item types, field codes, register
// indexes and the field step function. No dependencies.
package tfs_pkg;

  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_BLINK_HALF   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_HOLD  = 2'd2;

  localparam logic [8:0] BLINK_HALF_RST   = 9'd500;
  localparam logic [7:0] REPEAT_DELAY_RST = 8'd200;
  localparam logic [1:0] REPEAT_HOLD_RST  = 2'd2;

  // field codes
  localparam logic [2:0] FIELD_MONTH  = 3'd0;
  localparam logic [2:0] FIELD_DAY    = 3'd1;
  localparam logic [2:0] FIELD_HOUR   = 3'd2;
  localparam logic [2:0] FIELD_MINUTE = 3'd3;
  localparam logic [2:0] FIELD_NONE   = 3'd4;

  localparam logic [7:0] FIELD_MAX [4] = '{8'd12, 8'd31, 8'd23, 8'd59};

  typedef struct packed {
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
  } time_t;

  typedef struct packed {
    logic       cmd;
    logic       ms_tick;
    logic       sec_tick;
    logic [2:0] section;
    logic       down_button;
    logic       up_button;
    time_t      load;
  } in_item_t;

  typedef struct packed {
    time_t      vals;
    logic       blink_on;
    logic [2:0] selected_field;
  } out_item_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // one step of a field value, wrapping at its limits, modulo 256 otherwise
  function automatic logic [7:0] step_value(logic [7:0] v, logic [1:0] f, logic up);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (f <= 2'd1) ? 8'd1 : 8'd0;
    hi = FIELD_MAX[f];
    if (up) begin
      step_value = (v == hi) ? lo : v + 8'd1;
    end else begin
      step_value = (v == lo) ? hi : v - 8'd1;
    end
  endfunction

endpackage

FILE: src/tfs_in_reg.sv
// Input register of the clock time setter: holds one accepted item until
// the editor takes it. Depends on tfs_pkg.
module tfs_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tfs_pkg::in_item_t item_i,
  input  logic              take_i,
  output logic              valid_o,
  output tfs_pkg::in_item_t item_o
);

  logic              valid_q;
  tfs_pkg::in_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: src/tfs_editor.sv
// Editor state of the clock time setter: config registers, blink, button
// timers and the four time values, with the per-item next-state logic.
// Depends on tfs_pkg.
module tfs_editor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfs_pkg::cfg_wr_t   cfg_i,
  input  logic               step_i,
  input  tfs_pkg::in_item_t  item_i,
  output tfs_pkg::out_item_t result_o
);

  logic [8:0]     half_q;
  logic [7:0]     delay_q;
  logic [1:0]     hold_q;

  logic [8:0]     blink_cnt_q, blink_cnt_d;
  logic           phase_q, phase_d;
  logic [2:0]     tgt_q, tgt_d;
  logic [1:0]     hold_sec_q, hold_sec_d;
  logic [7:0]     rpt_q, rpt_d;
  logic           down_held_q, down_held_d;
  logic           up_held_q, up_held_d;
  tfs_pkg::time_t vals_q, vals_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= tfs_pkg::BLINK_HALF_RST;
      delay_q <= tfs_pkg::REPEAT_DELAY_RST;
      hold_q  <= tfs_pkg::REPEAT_HOLD_RST;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        tfs_pkg::CFG_BLINK_HALF:   half_q  <= cfg_i.data;
        tfs_pkg::CFG_REPEAT_DELAY: delay_q <= cfg_i.data[7:0];
        tfs_pkg::CFG_REPEAT_HOLD:  hold_q  <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0] cur;
    blink_cnt_d = blink_cnt_q;
    phase_d     = phase_q;
    tgt_d       = tgt_q;
    hold_sec_d  = hold_sec_q;
    rpt_d       = rpt_q;
    down_held_d = down_held_q;
    up_held_d   = up_held_q;
    vals_d      = vals_q;
    cur         = 8'd0;

    // ticks count first, whatever the command
    if (item_i.ms_tick) begin
      if (blink_cnt_d != 9'h1FF) blink_cnt_d = blink_cnt_d + 9'd1;
      if (rpt_d != 8'hFF) rpt_d = rpt_d + 8'd1;
    end
    if (item_i.sec_tick && hold_sec_d != 2'd3) hold_sec_d = hold_sec_d + 2'd1;

    if (item_i.cmd) begin
      vals_d = item_i.load;
    end else begin
      if (blink_cnt_d >= half_q) begin
        blink_cnt_d = 9'd0;
        phase_d     = !phase_d;
      end
      if (phase_d && item_i.section < tfs_pkg::FIELD_NONE) tgt_d = item_i.section;

      unique case (tgt_d)
        tfs_pkg::FIELD_MONTH:  cur = vals_q.month;
        tfs_pkg::FIELD_DAY:    cur = vals_q.day;
        tfs_pkg::FIELD_HOUR:   cur = vals_q.hour;
        tfs_pkg::FIELD_MINUTE: cur = vals_q.minute;
        default:               cur = 8'd0;
      endcase

      // down first, then up; both share the hold counter and repeat timer
      if (!item_i.down_button) begin
        down_held_d = 1'b0;
      end else begin
        if (!down_held_d) begin
          hold_sec_d = 2'd0;
          rpt_d      = 8'd0;
          cur        = tfs_pkg::step_value(cur, tgt_d[1:0], 1'b0);
        end
        down_held_d = 1'b1;
        if (hold_sec_d >= hold_q && rpt_d >= delay_q) begin
          cur   = tfs_pkg::step_value(cur, tgt_d[1:0], 1'b0);
          rpt_d = 8'd0;
        end
      end

      if (!item_i.up_button) begin
        up_held_d = 1'b0;
      end else begin
        if (!up_held_d) begin
          hold_sec_d = 2'd0;
          rpt_d      = 8'd0;
          cur        = tfs_pkg::step_value(cur, tgt_d[1:0], 1'b1);
        end
        up_held_d = 1'b1;
        if (hold_sec_d >= hold_q && rpt_d >= delay_q) begin
          cur   = tfs_pkg::step_value(cur, tgt_d[1:0], 1'b1);
          rpt_d = 8'd0;
        end
      end

      unique case (tgt_d)
        tfs_pkg::FIELD_MONTH:  vals_d.month  = cur;
        tfs_pkg::FIELD_DAY:    vals_d.day    = cur;
        tfs_pkg::FIELD_HOUR:   vals_d.hour   = cur;
        tfs_pkg::FIELD_MINUTE: vals_d.minute = cur;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_cnt_q  <= 9'd0;
      phase_q      <= 1'b0;
      tgt_q        <= tfs_pkg::FIELD_NONE;
      hold_sec_q   <= 2'd0;
      rpt_q        <= 8'd0;
      down_held_q  <= 1'b0;
      up_held_q    <= 1'b0;
      vals_q       <= '{month: 8'd4, day: 8'd27, hour: 8'd3, minute: 8'd15};
    end else if (step_i) begin
      blink_cnt_q  <= blink_cnt_d;
      phase_q      <= phase_d;
      tgt_q        <= tgt_d;
      hold_sec_q   <= hold_sec_d;
      rpt_q        <= rpt_d;
      down_held_q  <= down_held_d;
      up_held_q    <= up_held_d;
      vals_q       <= vals_d;
    end
  end

  assign result_o = '{vals: vals_d, blink_on: phase_d, selected_field: tgt_d};

endmodule

FILE: src/tfs_out_reg.sv
// Result register of the clock time setter: holds one result until the
// receiver takes it. Depends on tfs_pkg.
module tfs_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tfs_pkg::out_item_t result_i,
  input  logic               ready_i,
  output logic               valid_o,
  output logic               free_o,
  output tfs_pkg::out_item_t result_o
);

  logic               valid_q;
  tfs_pkg::out_item_t result_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: src/time_field_setter_auto_repeat_core.sv
// Top level of the clock time setter with auto-repeating buttons.
// Uses tfs_pkg, tfs_in_reg, tfs_editor and tfs_out_reg.
//
// Usage:
//  Each slave-side transfer carries one sample: tick flags, the section
//  being set, the two button levels and, with tuser high, four load
//  values. Each sample gives exactly one master-side transfer with the
//  four time values, the blink phase and the latched selected field.
//  A sample is registered at input, its result at output; one sample
//  per cycle is taken when the receiver keeps tready high. The whole edit
//  step (tick counts, blink toggle, up to four field steps) is one pass of
//  logic between the input register and the result register.
//  When the receiver stalls, the result register holds, the input
//  register fills with the next sample and tready drops until space frees.
//  Config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
//  clock edge; index 3 is ignored. Reset restores the register defaults
//  (500, 200, 2) and the time 4/27 03:15 with no field selected and both
//  channels empty.
module time_field_setter_auto_repeat_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tfs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tfs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: ms_tick, sec_tick, section[2:0], down_button, up_button,
  //        load_month, load_day, load_hour, load_minute, zero pad bit
  input  logic [tfs_pkg::InDataW-1:0]    s_axis_tdata_i,
  // tuser: cmd
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: month_value, day_value, hour_value, minute_value, blink_on,
  //        selected_field[2:0], zero pad
  output logic [tfs_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  tfs_pkg::in_item_t  in_item, cur_item;
  tfs_pkg::out_item_t result, out_item;
  tfs_pkg::cfg_wr_t   cfg;
  logic               cur_valid;
  logic               out_free;
  logic               advance;

  assign in_item = '{
    cmd:         s_axis_tuser_i,
    ms_tick:     s_axis_tdata_i[0],
    sec_tick:    s_axis_tdata_i[1],
    section:     s_axis_tdata_i[4:2],
    down_button: s_axis_tdata_i[5],
    up_button:   s_axis_tdata_i[6],
    load:        '{month:  s_axis_tdata_i[14:7],
                   day:    s_axis_tdata_i[22:15],
                   hour:   s_axis_tdata_i[30:23],
                   minute: s_axis_tdata_i[38:31]}
  };

  assign cfg     = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_wdata_i};
  assign advance = cur_valid && out_free;

  tfs_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .take_i  (advance),
    .valid_o (cur_valid),
    .item_o  (cur_item)
  );

  tfs_editor u_editor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (cur_item),
    .result_o (result)
  );

  tfs_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .free_o   (out_free),
    .result_o (out_item)
  );

  assign m_axis_tdata_o = {4'd0, out_item.selected_field, out_item.blink_on,
                           out_item.vals.minute, out_item.vals.hour,
                           out_item.vals.day, out_item.vals.month};

`ifndef SYNTHESIS
  // selection never leaves the legal codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_item.selected_field <= tfs_pkg::FIELD_NONE))
    else $error("selected field out of range");

  // a held sample is not dropped while the result side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid && m_axis_tvalid_o && !m_axis_tready_i) |=> cur_valid)
    else $error("held sample lost during stall");

  // every step delivers a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o)
    else $error("step produced no result");
`endif

endmodule

FILE: bench/time_field_setter_auto_repeat_core_test.sv
// Self-checking bench for the clock time setter core: predicts each
// readout of month, day, hour, minute, blink phase and selected field.
// Depends on tfs_pkg and time_field_setter_auto_repeat_core.
`timescale 1ns / 100ps

module time_field_setter_auto_repeat_core_test;

  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned HoldOffCycles = 120;
  // index beyond the register file, the core drops such writes
  localparam logic [tfs_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // Tracks the editor state and queues the readout each sample should give.
  class clock_edit_tracker;
    logic [8:0] blink_half;
    logic [7:0] repeat_delay;
    logic [1:0] repeat_hold;
    logic [8:0] blink_count;
    logic       blink_phase;
    logic [2:0] target;
    logic [1:0] hold_secs;
    logic [7:0] repeat_timer;
    logic       down_held;
    logic       up_held;
    logic [7:0] field_val [4];
    tfs_pkg::out_item_t pending_readouts [$];
    int unsigned errors;

    function new();
      blink_half   = tfs_pkg::BLINK_HALF_RST;
      repeat_delay = tfs_pkg::REPEAT_DELAY_RST;
      repeat_hold  = tfs_pkg::REPEAT_HOLD_RST;
      blink_count  = '0;
      blink_phase  = 1'b0;
      target       = tfs_pkg::FIELD_NONE;
      hold_secs    = '0;
      repeat_timer = '0;
      down_held    = 1'b0;
      up_held      = 1'b0;
      field_val[0] = 8'd4;
      field_val[1] = 8'd27;
      field_val[2] = 8'd3;
      field_val[3] = 8'd15;
      errors       = 0;
    endfunction

    function void write_reg(logic [tfs_pkg::CfgIdxW-1:0] idx,
                            logic [tfs_pkg::CfgDataW-1:0] data);
      case (idx)
        tfs_pkg::CFG_BLINK_HALF:   blink_half   = data;
        tfs_pkg::CFG_REPEAT_DELAY: repeat_delay = data[7:0];
        tfs_pkg::CFG_REPEAT_HOLD:  repeat_hold  = data[1:0];
        default: ;
      endcase
    endfunction

    function void step_target(bit up);
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] v;
      if (target >= tfs_pkg::FIELD_NONE) return;
      lo = (target <= tfs_pkg::FIELD_DAY) ? 8'd1 : 8'd0;
      case (target)
        tfs_pkg::FIELD_MONTH: hi = 8'd12;
        tfs_pkg::FIELD_DAY:   hi = 8'd31;
        tfs_pkg::FIELD_HOUR:  hi = 8'd23;
        default:              hi = 8'd59;
      endcase
      v = field_val[target[1:0]];
      // out-of-range values just wrap modulo 256
      if (up) begin
        v = (v == hi) ? lo : v + 8'd1;
      end else begin
        v = (v == lo) ? hi : v - 8'd1;
      end
      field_val[target[1:0]] = v;
    endfunction

    // returns the new held flag; hold counter and timer are shared
    function bit press(bit pressed, bit held, bit up);
      if (!pressed) return 1'b0;
      if (!held) begin
        hold_secs    = '0;
        repeat_timer = '0;
        step_target(up);
      end
      if (hold_secs >= repeat_hold && repeat_timer >= repeat_delay) begin
        step_target(up);
        repeat_timer = '0;
      end
      return 1'b1;
    endfunction

    function void take_sample(tfs_pkg::in_item_t s);
      tfs_pkg::out_item_t r;
      if (s.ms_tick) begin
        if (blink_count != 9'h1FF) blink_count++;
        if (repeat_timer != 8'hFF) repeat_timer++;
      end
      if (s.sec_tick && hold_secs != 2'd3) hold_secs++;
      if (s.cmd) begin
        field_val[0] = s.load.month;
        field_val[1] = s.load.day;
        field_val[2] = s.load.hour;
        field_val[3] = s.load.minute;
      end else begin
        if (blink_count >= blink_half) begin
          blink_count = '0;
          blink_phase = ~blink_phase;
        end
        if (blink_phase && s.section < tfs_pkg::FIELD_NONE) target = s.section;
        down_held = press(s.down_button, down_held, 1'b0);
        up_held   = press(s.up_button, up_held, 1'b1);
      end
      r.vals.month     = field_val[0];
      r.vals.day       = field_val[1];
      r.vals.hour      = field_val[2];
      r.vals.minute    = field_val[3];
      r.blink_on       = blink_phase;
      r.selected_field = target;
      pending_readouts.push_back(r);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_readout(logic [tfs_pkg::OutDataW-1:0] d);
      tfs_pkg::out_item_t want;
      if (pending_readouts.size() == 0) begin
        errors++;
        $display("%0t: unexpected readout, expected none, actual %h", $time, d);
        return;
      end
      want = pending_readouts.pop_front();
      compare("month", want.vals.month, d[7:0]);
      compare("day", want.vals.day, d[15:8]);
      compare("hour", want.vals.hour, d[23:16]);
      compare("minute", want.vals.minute, d[31:24]);
      compare("blink_on", want.blink_on, d[32]);
      compare("selected_field", want.selected_field, d[35:33]);
    endfunction
  endclass

  logic                         clk_i     = 1'b0;
  logic                         rst_ni    = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [tfs_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [tfs_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic [tfs_pkg::InDataW-1:0]  in_data   = '0;
  logic                         in_cmd    = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [tfs_pkg::OutDataW-1:0] out_data;

  clock_edit_tracker tracker = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req   = 1'b0;
  bit          down_lvl       = 1'b0;
  bit          up_lvl         = 1'b0;
  int unsigned cycle_count    = 0;

  time_field_setter_auto_repeat_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_cmd),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // tdata from bit 0: ms, sec, section, down, up, four load values, pad
  function automatic logic [tfs_pkg::InDataW-1:0] pack_sample(tfs_pkg::in_item_t s);
    return {1'b0, s.load.minute, s.load.hour, s.load.day, s.load.month,
            s.up_button, s.down_button, s.section, s.sec_tick, s.ms_tick};
  endfunction

  function automatic tfs_pkg::in_item_t sample(bit cmd, bit ms, bit sec, logic [2:0] sect,
                                               bit dn, bit up, logic [7:0] mo,
                                               logic [7:0] dy, logic [7:0] hr,
                                               logic [7:0] mi);
    tfs_pkg::in_item_t s;
    s.cmd         = cmd;
    s.ms_tick     = ms;
    s.sec_tick    = sec;
    s.section     = sect;
    s.down_button = dn;
    s.up_button   = up;
    s.load.month  = mo;
    s.load.day    = dy;
    s.load.hour   = hr;
    s.load.minute = mi;
    return s;
  endfunction

  // mostly in-range values, with limits and wrap-around cases mixed in
  function automatic logic [7:0] pick_load(logic [7:0] hi);
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: return 8'($urandom_range(hi));
      2: return hi;
      default: return ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
    endcase
  endfunction

  // buttons behave as held levels most of the time, with some chatter
  function automatic tfs_pkg::in_item_t random_sample();
    tfs_pkg::in_item_t s;
    logic [2:0]        sect;
    if ($urandom_range(9) == 0) begin
      down_lvl = 1'($urandom_range(1));
      up_lvl   = 1'($urandom_range(1));
    end else begin
      if ($urandom_range(7) == 0) down_lvl = ~down_lvl;
      if ($urandom_range(7) == 0) up_lvl = ~up_lvl;
    end
    sect = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
    s = sample($urandom_range(99) < 6, $urandom_range(99) < 75, $urandom_range(99) < 30,
               sect, down_lvl, up_lvl, pick_load(8'd12), pick_load(8'd31),
               pick_load(8'd23), pick_load(8'd59));
    return s;
  endfunction

  task automatic send_sample(tfs_pkg::in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= pack_sample(s);
    in_cmd   <= s.cmd;
    do @(posedge clk_i); while (!in_ready);
    tracker.take_sample(s);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_readouts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [tfs_pkg::CfgIdxW-1:0] idx,
                           logic [tfs_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(logic [8:0] blink, logic [7:0] delay, logic [1:0] hold);
    wait_idle();
    write_cfg(tfs_pkg::CFG_BLINK_HALF, blink);
    write_cfg(tfs_pkg::CFG_REPEAT_DELAY, {1'b0, delay});
    write_cfg(tfs_pkg::CFG_REPEAT_HOLD, {7'd0, hold});
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int unsigned count, int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_sample(random_sample());
  endtask

  // result side: check each transfer, then choose the next tready
  initial begin
    int unsigned hold_left;
    bit          hold_off_done;
    hold_left     = 0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) tracker.check_readout(out_data);
      if (hold_off_req && !hold_off_done) begin
        hold_left     = HoldOffCycles;
        hold_off_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, then loads at the extremes and at the field limits
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_MONTH, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(1, 1, 1, tfs_pkg::FIELD_NONE, 1, 1, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(1, 0, 0, 3'd7, 0, 0, 8'd255, 8'd255, 8'd255, 8'd255));
    send_sample(sample(1, 0, 0, tfs_pkg::FIELD_DAY, 0, 0, 8'd12, 8'd31, 8'd23, 8'd59));

    // zero registers: phase toggles every edit, a fresh press steps twice
    configure(9'd0, 8'd0, 2'd0);
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_MONTH, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_MINUTE, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_MINUTE, 0, 1, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 1, 1, 3'd5, 1, 1, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(1, 0, 0, tfs_pkg::FIELD_MONTH, 0, 0, 8'd0, 8'd0, 8'd0, 8'd200));
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_MONTH, 1, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 1, 1, 3'd7, 0, 1, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_MINUTE, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_MINUTE, 0, 1, 8'd0, 8'd0, 8'd0, 8'd0));

    // short periods: latching, wrap at both limits, held repeat
    configure(9'd1, 8'd1, 2'd0);
    send_sample(sample(0, 1, 0, tfs_pkg::FIELD_DAY, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(1, 0, 0, tfs_pkg::FIELD_DAY, 0, 0, 8'd1, 8'd31, 8'd0, 8'd23));
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_DAY, 0, 1, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 1, 0, tfs_pkg::FIELD_HOUR, 0, 1, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 1, 0, tfs_pkg::FIELD_HOUR, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_HOUR, 1, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 1, 1, tfs_pkg::FIELD_HOUR, 1, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 1, 0, tfs_pkg::FIELD_MONTH, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_sample(sample(0, 0, 0, tfs_pkg::FIELD_MONTH, 1, 0, 8'd0, 8'd0, 8'd0, 8'd0));

    configure(9'd1, 8'd1, 2'd0);
    run_random(300, 0, 0);

    configure(9'd511, 8'd255, 2'd3);
    write_cfg(CFG_UNUSED, 9'h1FF);
    cfg_we <= 1'b0;
    run_random(250, 88, 0);

    configure(9'd3, 8'd5, 2'd1);
    run_random(300, 0, 88);

    // long receiver hold-off fills the core, then a full drain mid-phase
    configure(9'd2, 8'd3, 2'd2);
    hold_off_req = 1'b1;
    run_random(200, 0, 0);
    wait_idle();
    run_random(200, 0, 0);

    configure(9'd7, 8'd1, 2'd3);
    run_random(250, 37, 37);

    configure(9'd4, 8'd2, 2'd1);
    run_random(250, 37, 37);

    wait_idle();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
